// ===== design/burner_ignition_controller_macros.svh =====
// assertion macros for the burner ignition controller checker
`ifndef BURNER_IGNITION_CONTROLLER_MACROS_SVH
`define BURNER_IGNITION_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("burner controller assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("burner controller assertion failed");

`endif

// ===== design/bic_pkg.sv =====
// shared types and constants for the burner ignition controller
package bic_pkg;

	localparam int TIMER_BITS = 16;
	localparam int LEN_BITS   = 16;
	localparam int CMP_BITS   = (TIMER_BITS > LEN_BITS) ? TIMER_BITS : LEN_BITS;
	localparam int TEMP_BITS  = 12;
	localparam int WORD_BITS  = 16;
	localparam int ADDR_BITS  = 4;
	localparam int DATA_BITS  = 32;
	localparam int FAULT_BIT  = 2;

	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_IGNITING = 2'd1;
	localparam logic [1:0] MODE_HEATING  = 2'd2;
	localparam logic [1:0] MODE_ERROR    = 2'd3;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_READING = 1'b1;

	localparam logic [1:0] REG_SETPOINT   = 2'd0;
	localparam logic [1:0] REG_HYSTERESIS = 2'd1;
	localparam logic [1:0] REG_LEAD       = 2'd2;
	localparam logic [1:0] REG_OVERLAP    = 2'd3;

	localparam logic [TEMP_BITS-1:0] RST_SETPOINT   = 12'd320;
	localparam logic [TEMP_BITS-1:0] RST_HYSTERESIS = 12'd20;
	localparam logic [LEN_BITS-1:0]  RST_LEAD       = 16'd3000;
	localparam logic [LEN_BITS-1:0]  RST_OVERLAP    = 16'd1000;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_IGNITING = 4'b0010,
		ST_HEATING  = 4'b0100,
		ST_ERROR    = 4'b1000
	} burner_state_t;

	typedef struct packed {
		logic [TEMP_BITS-1:0] setpoint_q;
		logic [TEMP_BITS-1:0] hysteresis_q;
		logic [LEN_BITS-1:0]  ignite_lead_ms;
		logic [LEN_BITS-1:0]  overlap_ms;
	} cfg_t;

	typedef struct packed {
		logic                 opcode;
		logic [WORD_BITS-1:0] sensor_word;
		logic                 read_ok;
	} item_t;

	typedef struct packed {
		logic                 igniter_on;
		logic                 gas_on;
		logic [1:0]           mode;
		logic [TEMP_BITS-1:0] temperature_q;
		logic                 temperature_valid;
	} result_t;

endpackage

// ===== design/bic_cfg.sv =====
// apb configuration registers for the burner ignition controller
module bic_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bic_pkg::ADDR_BITS-1:0] paddr,
	input  logic [bic_pkg::DATA_BITS-1:0] pwdata,
	output logic [bic_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output bic_pkg::cfg_t                 cfg
);

	bic_pkg::cfg_t cfg_q;
	logic [1:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_q     <= bic_pkg::RST_SETPOINT;
			cfg_q.hysteresis_q   <= bic_pkg::RST_HYSTERESIS;
			cfg_q.ignite_lead_ms <= bic_pkg::RST_LEAD;
			cfg_q.overlap_ms     <= bic_pkg::RST_OVERLAP;
		end else if (wr_en) begin
			unique case (reg_idx)
				bic_pkg::REG_SETPOINT:   cfg_q.setpoint_q     <= pwdata[bic_pkg::TEMP_BITS-1:0];
				bic_pkg::REG_HYSTERESIS: cfg_q.hysteresis_q   <= pwdata[bic_pkg::TEMP_BITS-1:0];
				bic_pkg::REG_LEAD:       cfg_q.ignite_lead_ms <= pwdata[bic_pkg::LEN_BITS-1:0];
				bic_pkg::REG_OVERLAP:    cfg_q.overlap_ms     <= pwdata[bic_pkg::LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bic_pkg::REG_SETPOINT:   prdata = bic_pkg::DATA_BITS'(cfg_q.setpoint_q);
			bic_pkg::REG_HYSTERESIS: prdata = bic_pkg::DATA_BITS'(cfg_q.hysteresis_q);
			bic_pkg::REG_LEAD:       prdata = bic_pkg::DATA_BITS'(cfg_q.ignite_lead_ms);
			bic_pkg::REG_OVERLAP:    prdata = bic_pkg::DATA_BITS'(cfg_q.overlap_ms);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== design/bic_ctrl.sv =====
// burner sequence state and next-state logic for one transaction
module bic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  bic_pkg::item_t    item,
	input  bic_pkg::cfg_t     cfg,
	output bic_pkg::result_t  result
);

	localparam logic [bic_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

	bic_pkg::burner_state_t            state_q, state_d;
	logic                              gas_phase_q, gas_phase_d;
	logic [bic_pkg::TIMER_BITS-1:0]    timer_q, timer_d;
	logic [bic_pkg::TEMP_BITS-1:0]     temp_q, temp_d;
	logic                              known_q, known_d;
	logic                              igniter_q, igniter_d;
	logic                              valve_q, valve_d;

	logic [bic_pkg::TIMER_BITS-1:0]    timer_inc;
	logic [bic_pkg::LEN_BITS-1:0]      phase_len;
	logic                              phase_done;
	logic [bic_pkg::TEMP_BITS:0]       relight_sum;
	logic                              relight;
	logic                              reached;

	always_comb begin
		timer_inc   = (timer_q == TIMER_MAX) ? timer_q : timer_q + bic_pkg::TIMER_BITS'(1);
		phase_len   = gas_phase_q ? cfg.overlap_ms : cfg.ignite_lead_ms;
		// a length beyond the timer range ends the phase when the timer saturates
		phase_done  = (bic_pkg::CMP_BITS'(timer_inc) >= bic_pkg::CMP_BITS'(phase_len))
			|| (timer_inc == TIMER_MAX);
		// temperature below setpoint minus hysteresis, without a signed threshold
		relight_sum = {1'b0, temp_q} + {1'b0, cfg.hysteresis_q};
		relight     = known_q && (relight_sum < {1'b0, cfg.setpoint_q});
		reached     = known_q && (temp_q >= cfg.setpoint_q);
	end

	always_comb begin
		state_d     = state_q;
		gas_phase_d = gas_phase_q;
		timer_d     = timer_q;
		temp_d      = temp_q;
		known_d     = known_q;
		igniter_d   = igniter_q;
		valve_d     = valve_q;
		if (item.opcode == bic_pkg::OP_TICK) begin
			unique case (state_q)
				bic_pkg::ST_IDLE: begin
					if (relight) begin
						state_d     = bic_pkg::ST_IGNITING;
						gas_phase_d = 1'b0;
						timer_d     = '0;
						igniter_d   = 1'b1;
						valve_d     = 1'b0;
					end
				end
				bic_pkg::ST_IGNITING: begin
					if (!phase_done) begin
						timer_d = timer_inc;
					end else if (!gas_phase_q) begin
						valve_d     = 1'b1;
						gas_phase_d = 1'b1;
						timer_d     = '0;
					end else begin
						igniter_d   = 1'b0;
						gas_phase_d = 1'b0;
						timer_d     = '0;
						state_d     = bic_pkg::ST_HEATING;
					end
				end
				bic_pkg::ST_HEATING: begin
					if (reached) begin
						igniter_d = 1'b0;
						valve_d   = 1'b0;
						state_d   = bic_pkg::ST_IDLE;
					end
				end
				default: begin
					igniter_d = 1'b0;
					valve_d   = 1'b0;
				end
			endcase
		end else if (!item.read_ok || item.sensor_word[bic_pkg::FAULT_BIT]) begin
			// a fault bit also drops the temperature, a failed read keeps it
			if (item.read_ok) begin
				known_d = 1'b0;
			end
			state_d     = bic_pkg::ST_ERROR;
			gas_phase_d = 1'b0;
			timer_d     = '0;
			igniter_d   = 1'b0;
			valve_d     = 1'b0;
		end else begin
			// top bit of the 13-bit reading saturates to full scale
			temp_d  = item.sensor_word[15] ? '1 : item.sensor_word[14:3];
			known_d = 1'b1;
			if (state_q == bic_pkg::ST_ERROR) begin
				state_d = bic_pkg::ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bic_pkg::ST_IDLE;
			gas_phase_q <= 1'b0;
			timer_q     <= '0;
			temp_q      <= '0;
			known_q     <= 1'b0;
			igniter_q   <= 1'b0;
			valve_q     <= 1'b0;
		end else if (en) begin
			state_q     <= state_d;
			gas_phase_q <= gas_phase_d;
			timer_q     <= timer_d;
			temp_q      <= temp_d;
			known_q     <= known_d;
			igniter_q   <= igniter_d;
			valve_q     <= valve_d;
		end
	end

	always_comb begin
		result.igniter_on        = igniter_d;
		result.gas_on            = valve_d;
		result.temperature_q     = temp_d;
		result.temperature_valid = known_d;
		unique case (state_d)
			bic_pkg::ST_IDLE:     result.mode = bic_pkg::MODE_IDLE;
			bic_pkg::ST_IGNITING: result.mode = bic_pkg::MODE_IGNITING;
			bic_pkg::ST_HEATING:  result.mode = bic_pkg::MODE_HEATING;
			default:              result.mode = bic_pkg::MODE_ERROR;
		endcase
	end

endmodule

// ===== design/burner_ignition_controller.sv =====
// Gas burner ignition controller. Each input transaction (a 1 ms tick or a thermocouple word)
// produces exactly one result transaction with the drive outputs, mode and stored temperature
// as they stand after that item. One item is accepted per clock while in_stall is low: the
// item is captured in an input register, the control state is updated as it moves into the
// result register, and the result register holds it while out_stall is high. Configuration
// registers are written through the apb port at byte addresses 0, 4, 8 and 12.
module burner_ignition_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [bic_pkg::WORD_BITS-1:0] sensor_word,
	input  logic                          read_ok,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          igniter_on,
	output logic                          gas_on,
	output logic [1:0]                    mode,
	output logic [bic_pkg::TEMP_BITS-1:0] temperature_q,
	output logic                          temperature_valid,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bic_pkg::ADDR_BITS-1:0] paddr,
	input  logic [bic_pkg::DATA_BITS-1:0] pwdata,
	output logic [bic_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);

	bic_pkg::cfg_t    cfg;
	bic_pkg::item_t   item_s1;
	bic_pkg::result_t res_next;
	bic_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             advance;

	// result register can take a new value when empty or being drained
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.opcode      <= opcode;
			item_s1.sensor_word <= sensor_word;
			item_s1.read_ok     <= read_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	bic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	assign out_valid         = valid_s2;
	assign igniter_on        = res_s2.igniter_on;
	assign gas_on            = res_s2.gas_on;
	assign mode              = res_s2.mode;
	assign temperature_q     = res_s2.temperature_q;
	assign temperature_valid = res_s2.temperature_valid;

endmodule

// ===== design/bic_checker.sv =====
// port-level checker for the burner ignition controller, bound to the top level
`include "burner_ignition_controller_macros.svh"

module bic_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          igniter_on,
	input logic                          gas_on,
	input logic [1:0]                    mode,
	input logic [bic_pkg::TEMP_BITS-1:0] temperature_q,
	input logic                          temperature_valid
);

	// a stalled result transaction holds
	`BIC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(igniter_on) && $stable(gas_on) && $stable(mode) && $stable(temperature_q) && $stable(temperature_valid))

	// no drive outside ignition and heating
	`BIC_ASSERT_IMPL(a_off_when_idle_or_error, clk, arst_n, out_valid && (mode == bic_pkg::MODE_IDLE || mode == bic_pkg::MODE_ERROR), !igniter_on && !gas_on)

	`BIC_ASSERT_IMPL(a_igniting_sparks, clk, arst_n, out_valid && mode == bic_pkg::MODE_IGNITING, igniter_on)

	// heating runs on gas alone
	`BIC_ASSERT_IMPL(a_heating_gas_only, clk, arst_n, out_valid && mode == bic_pkg::MODE_HEATING, gas_on && !igniter_on)

endmodule

bind burner_ignition_controller bic_checker u_bic_checker (.*);
